[hdl/sdas_pkg.sv]
// Shared types and constants of the step/direction axis simulator.
// Used by every module of the block; depends on nothing else.
package sdas_pkg;

  localparam int NUM_AXES     = 4;
  localparam int POS_WIDTH    = 32;
  localparam int AXIS_W       = $clog2(NUM_AXES);
  localparam int LIMITED_AXES = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int IN_TDATA_W   = 8;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 48;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [1:0] CMD_STEP = 2'd0;
  localparam logic [1:0] CMD_DIR  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic signed [POS_WIDTH-1:0] POS_HI = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_LO = {1'b1, {(POS_WIDTH-1){1'b0}}};

  localparam logic [NUM_AXES-1:0] INV_DIR_RESET = NUM_AXES'(4'h4);

  localparam logic signed [POS_WIDTH-1:0] POS_RESET [NUM_AXES] = '{
    POS_WIDTH'(10000), POS_WIDTH'(10000), POS_WIDTH'(1600), POS_WIDTH'(0)
  };
  localparam logic signed [POS_WIDTH-1:0] LO_RESET [LIMITED_AXES] = '{
    POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0)
  };
  localparam logic signed [POS_WIDTH-1:0] HI_RESET [LIMITED_AXES] = '{
    POS_WIDTH'(18400), POS_WIDTH'(18300), POS_WIDTH'(74400)
  };

  typedef enum logic [1:0] {
    OP_NOP,
    OP_STEP,
    OP_DIR,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [AXIS_W-1:0] axis;
    logic              level;
  } item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_DIR = 3'd0,
    CFG_X_MIN   = 3'd1,
    CFG_X_MAX   = 3'd2,
    CFG_Y_MIN   = 3'd3,
    CFG_Y_MAX   = 3'd4,
    CFG_Z_MIN   = 3'd5,
    CFG_Z_MAX   = 3'd6
  } cfg_idx_e;

endpackage

[hdl/sdas_front.sv]
// Front end: takes input items from the stream and classifies each command.
// Depends on sdas_pkg; feeds sdas_queue.
module sdas_front import sdas_pkg::*; (
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // axis[1:0], level[2], zero pad
  input  logic [IN_TUSER_W-1:0] s_axis_tuser,   // command[1:0]
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output item_t                 q_item_o
);

  op_e op;

  always_comb begin
    unique case (s_axis_tuser)
      CMD_STEP: op = s_axis_tdata[AXIS_W] ? OP_STEP : OP_NOP;
      CMD_DIR:  op = OP_DIR;
      CMD_TICK: op = OP_TICK;
      default:  op = OP_NOP;
    endcase
  end

  assign s_axis_tready  = !q_full_i;
  assign q_push_o       = s_axis_tvalid && !q_full_i;
  assign q_item_o.op    = op;
  assign q_item_o.axis  = s_axis_tdata[AXIS_W-1:0];
  assign q_item_o.level = s_axis_tdata[AXIS_W];

endmodule

[hdl/sdas_queue.sv]
// Short item queue between the front end and the execution stage.
// Depends on sdas_pkg for the item type and depth.
module sdas_queue import sdas_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hdl/sdas_back.sv]
// Execution stage, fed by sdas_queue: holds axis state and limits, runs one
// item per cycle unless stalled, registers the result. Depends on sdas_pkg.
module sdas_back import sdas_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   q_empty_i,
  input  item_t                  q_item_i,
  output logic                   q_pop_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [NUM_AXES-1:0]               inv_q;
  logic signed [POS_WIDTH-1:0]       lo_q [LIMITED_AXES];
  logic signed [POS_WIDTH-1:0]       hi_q [LIMITED_AXES];
  logic signed [POS_WIDTH-1:0]       pos_q [NUM_AXES];
  logic signed [POS_WIDTH-1:0]       pos_d [NUM_AXES];
  logic [NUM_AXES-1:0]               dir_q, dir_d;
  logic [NUM_AXES-1:0]               min_q, min_d;
  logic [NUM_AXES-1:0]               max_q, max_d;
  logic                              out_valid_q;
  logic [OUT_TDATA_W-1:0]            out_q, out_d;

  logic signed [POS_WIDTH-1:0]       lo_all [NUM_AXES];
  logic signed [POS_WIDTH-1:0]       hi_all [NUM_AXES];
  logic                              exec;
  logic [AXIS_W-1:0]                 ax;
  logic                              up;
  logic signed [POS_WIDTH:0]         cur_ext;
  logic signed [POS_WIDTH:0]         inc;
  logic signed [POS_WIDTH:0]         dec;
  logic signed [POS_WIDTH-1:0]       step_pos;

  assign cfg_ready_o   = 1'b1;
  assign exec          = !q_empty_i && (!out_valid_q || m_axis_tready);
  assign q_pop_o       = exec;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign ax            = q_item_i.axis;

  always_comb begin
    for (int a = 0; a < LIMITED_AXES; a++) begin
      lo_all[a] = lo_q[a];
      hi_all[a] = hi_q[a];
    end
    for (int a = LIMITED_AXES; a < NUM_AXES; a++) begin
      lo_all[a] = POS_LO;
      hi_all[a] = POS_HI;
    end
  end

  always_comb begin
    up       = dir_q[ax] ^ inv_q[ax];
    cur_ext  = (POS_WIDTH+1)'(pos_q[ax]);
    inc      = cur_ext + 2'sb01;
    dec      = cur_ext - 2'sb01;
    if (up) begin
      step_pos = (inc > (POS_WIDTH+1)'(hi_all[ax])) ? hi_all[ax] : inc[POS_WIDTH-1:0];
    end else begin
      step_pos = (dec < (POS_WIDTH+1)'(lo_all[ax])) ? lo_all[ax] : dec[POS_WIDTH-1:0];
    end
  end

  always_comb begin
    pos_d = pos_q;
    dir_d = dir_q;
    min_d = min_q;
    max_d = max_q;
    case (q_item_i.op)
      OP_STEP: begin
        pos_d[ax] = step_pos;
        if (up) begin
          min_d[ax] = 1'b0;
        end else begin
          max_d[ax] = 1'b0;
        end
      end
      OP_DIR: begin
        dir_d[ax] = q_item_i.level;
      end
      OP_TICK: begin
        for (int a = 0; a < LIMITED_AXES; a++) begin
          if (pos_q[a] <= lo_q[a]) begin
            min_d[a] = 1'b1;
          end
          if (pos_q[a] >= hi_q[a]) begin
            max_d[a] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    out_d = '0;
    out_d[POS_WIDTH-1:0]  = pos_d[ax];
    out_d[POS_WIDTH]      = min_d[ax];
    out_d[POS_WIDTH+1]    = max_d[ax];
    out_d[POS_WIDTH+2]    = min_d[ax] | max_d[ax];
    out_d[POS_WIDTH+3 +: 2*NUM_AXES] = {max_d, min_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q       <= INV_DIR_RESET;
      lo_q        <= LO_RESET;
      hi_q        <= HI_RESET;
      pos_q       <= POS_RESET;
      dir_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_INV_DIR: inv_q    <= cfg_data_i[NUM_AXES-1:0];
          CFG_X_MIN:   lo_q[0]  <= cfg_data_i;
          CFG_X_MAX:   hi_q[0]  <= cfg_data_i;
          CFG_Y_MIN:   lo_q[1]  <= cfg_data_i;
          CFG_Y_MAX:   hi_q[1]  <= cfg_data_i;
          CFG_Z_MIN:   lo_q[2]  <= cfg_data_i;
          CFG_Z_MAX:   hi_q[2]  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (exec) begin
        pos_q       <= pos_d;
        dir_q       <= dir_d;
        min_q       <= min_d;
        max_q       <= max_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  a_tick_only_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && q_item_i.op == OP_TICK |=>
      ((min_q & $past(min_q)) == $past(min_q)) && ((max_q & $past(max_q)) == $past(max_q)))
    else $error("tick cleared an endstop flag");

  a_dir_keeps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && q_item_i.op == OP_DIR |=>
      pos_q[0] == $past(pos_q[0]) && pos_q[1] == $past(pos_q[1]) &&
      pos_q[2] == $past(pos_q[2]) && pos_q[3] == $past(pos_q[3]) &&
      min_q == $past(min_q) && max_q == $past(max_q))
    else $error("direction command changed position or flags");

  a_nop_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && q_item_i.op == OP_NOP |=>
      dir_q == $past(dir_q) && min_q == $past(min_q) && max_q == $past(max_q))
    else $error("idle command changed state");

  a_stall_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !q_pop_o)
    else $error("item executed while result still waiting");
`endif

endmodule

[hdl/step_dir_axis_simulator.sv]
// Top level of the step/direction axis simulator.
// Depends on sdas_pkg, sdas_front, sdas_queue and sdas_back.
//
// Channel   Direction  Payload
// s_axis    in         tuser: command; tdata: axis, level
// m_axis    out        tdata: position, at_min, at_max, diag, flag_byte
// cfg       in         cfg_index_i, cfg_data_i; always ready
//
// One item per cycle unless the output stalls; the execute stage sets the rate.
// Accepted items pass the queue, then execute into the output register.
// Reset clears the queue and output register and loads the reset limits.
// A stalled output holds its result while the two-entry queue keeps accepting
// until it is full, which drops s_axis_tready.
module step_dir_axis_simulator import sdas_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // axis[1:0], level[2], zero pad
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // command[1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // position[31:0], at_min[32], at_max[33], diag[34], flag_byte[42:35], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  item_t q_in;
  item_t q_out;

  sdas_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  sdas_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_out)
  );

  sdas_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_empty_i     (q_empty),
    .q_item_i      (q_out),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[tb/tb_step_dir_axis_simulator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the four-axis step/direction simulator.
// Drives command items with random idling, predicts every status item and
// checks it field by field. Depends on sdas_pkg and step_dir_axis_simulator.
module tb_step_dir_axis_simulator;
  import sdas_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 230;
  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD   = 150;
  localparam longint POS_TOP    = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
  localparam longint POS_BOTTOM = -POS_TOP - 1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [AXIS_W-1:0] axis;
    logic              level;
  } axis_cmd_t;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] position;
    logic                        at_min;
    logic                        at_max;
    logic                        diag;
    logic [7:0]                  flag_byte;
  } axis_status_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  axis_cmd_t    pending_cmds[$];
  axis_status_t expected_status[$];
  axis_cmd_t    next_cmd;
  axis_status_t want;

  logic signed [POS_WIDTH-1:0] axis_pos [NUM_AXES];
  logic signed [POS_WIDTH-1:0] lim_lo [NUM_AXES];
  logic signed [POS_WIDTH-1:0] lim_hi [NUM_AXES];
  logic [NUM_AXES-1:0]         inv_mask;
  logic [NUM_AXES-1:0]         dir_bits;
  logic [7:0]                  endstops;

  logic in_fire = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   reg_writes = 0;
  int   mismatches = 0;

  step_dir_axis_simulator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic axis_status_t advance_axes(axis_cmd_t c);
    axis_status_t s;
    longint p;
    if (c.cmd == CMD_STEP && c.level) begin
      p = axis_pos[c.axis];
      if (inv_mask[c.axis] ^ dir_bits[c.axis]) begin
        endstops[c.axis] = 1'b0;
        p = p + 1;
        if (p > lim_hi[c.axis]) p = lim_hi[c.axis];
      end else begin
        endstops[4 + c.axis] = 1'b0;
        p = p - 1;
        if (p < lim_lo[c.axis]) p = lim_lo[c.axis];
      end
      if (p > POS_TOP) p = POS_TOP;
      if (p < POS_BOTTOM) p = POS_BOTTOM;
      axis_pos[c.axis] = p[POS_WIDTH-1:0];
    end else if (c.cmd == CMD_DIR) begin
      dir_bits[c.axis] = c.level;
    end else if (c.cmd == CMD_TICK) begin
      for (int a = 0; a < LIMITED_AXES; a++) begin
        if (axis_pos[a] <= lim_lo[a]) endstops[a] = 1'b1;
        if (axis_pos[a] >= lim_hi[a]) endstops[4 + a] = 1'b1;
      end
    end
    s.position  = axis_pos[c.axis];
    s.at_min    = endstops[c.axis];
    s.at_max    = endstops[4 + c.axis];
    s.diag      = s.at_min | s.at_max;
    s.flag_byte = endstops;
    return s;
  endfunction

  function automatic void check_field(string name, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= next_cmd.cmd;
        s_axis_tdata  <= {5'b0, next_cmd.level, next_cmd.axis};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served  <= hold_requests;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && (s_axis_tready === 1'b1);
    if (s_axis_tvalid && s_axis_tready) begin
      expected_status.push_back(
        advance_axes(axis_cmd_t'({s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[2]})));
      items_sent++;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (expected_status.size() == 0) begin
        $display("%0t: status item with none expected: expected nothing, got %h",
                 $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("position", want.position, $signed(m_axis_tdata[31:0]));
        check_field("at_min", want.at_min, m_axis_tdata[32]);
        check_field("at_max", want.at_max, m_axis_tdata[33]);
        check_field("diag", want.diag, m_axis_tdata[34]);
        check_field("flag_byte", want.flag_byte, m_axis_tdata[42:35]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d status items outstanding",
               $time, STALL_LIMIT, expected_status.size());
      $display("tb_step_dir_axis_simulator failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_cmd(logic [1:0] cmd, logic [AXIS_W-1:0] ax, logic lvl);
    pending_cmds.push_back({cmd, ax, lvl});
  endtask

  task automatic queue_random(int count);
    int added;
    int ax;
    int steps;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 80) begin
        ax = $urandom_range(NUM_AXES - 1);
        steps = $urandom_range(10, 1);
        queue_cmd(CMD_DIR, AXIS_W'(ax), 1'($urandom_range(1)));
        repeat (steps) queue_cmd(CMD_STEP, AXIS_W'(ax), $urandom_range(9) != 0);
        added += steps + 1;
        if ($urandom_range(2) == 0) begin
          queue_cmd(CMD_TICK, AXIS_W'($urandom_range(NUM_AXES - 1)),
                    1'($urandom_range(1)));
          added++;
        end
      end else begin
        queue_cmd(2'($urandom_range(3)), AXIS_W'($urandom_range(NUM_AXES - 1)),
                  1'($urandom_range(1)));
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_INV_DIR: inv_mask = val[NUM_AXES-1:0];
      CFG_X_MIN:   lim_lo[0] = val;
      CFG_X_MAX:   lim_hi[0] = val;
      CFG_Y_MIN:   lim_lo[1] = val;
      CFG_Y_MAX:   lim_hi[1] = val;
      CFG_Z_MIN:   lim_lo[2] = val;
      CFG_Z_MAX:   lim_hi[2] = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(logic [3:0] inv, logic [31:0] xl, logic [31:0] xh,
                           logic [31:0] yl, logic [31:0] yh, logic [31:0] zl,
                           logic [31:0] zh);
    write_reg(CFG_INV_DIR, 32'(inv));
    write_reg(CFG_X_MIN, xl);
    write_reg(CFG_X_MAX, xh);
    write_reg(CFG_Y_MIN, yl);
    write_reg(CFG_Y_MAX, yh);
    write_reg(CFG_Z_MIN, zl);
    write_reg(CFG_Z_MAX, zh);
  endtask

  function automatic logic [31:0] near_zero();
    return 32'(int'($urandom_range(8)) - 4);
  endfunction

  task automatic run_phase(int k);
    case (k)
      0: write_all(4'($urandom_range(15)), near_zero(), near_zero() + 6, near_zero(),
                   near_zero() + 3, near_zero(), near_zero() + 8);
      1: write_all(4'hF, POS_LO, POS_HI, POS_HI, POS_LO, near_zero(), near_zero());
      2: write_all(4'h0, near_zero(), near_zero(), near_zero(), near_zero() + 5,
                   near_zero(), near_zero() + 2);
      3: write_all(4'($urandom_range(15)), POS_HI, POS_LO, POS_LO, POS_HI,
                   $urandom(), $urandom());
      4: write_all(4'($urandom_range(15)), POS_LO, POS_HI, near_zero(), near_zero() + 4,
                   near_zero() - 2, near_zero() + 2);
      default: write_all(4'h4, near_zero(), near_zero() + 3, near_zero(),
                         near_zero() + 3, near_zero(), near_zero() + 3);
    endcase
    send_idle_pct = (k < 2) ? 32 : (k < 4) ? 59 : 0;
    recv_idle_pct = (k < 2) ? 59 : (k < 4) ? 32 : 0;
    queue_random(PHASE_ITEMS / 2);
    if (k == 4) hold_requests++;
    wait_drained();
    queue_random(PHASE_ITEMS / 2);
    wait_drained();
  endtask

  initial begin
    axis_pos = '{32'sd10000, 32'sd10000, 32'sd1600, 32'sd0};
    lim_lo   = '{32'sd0, 32'sd0, 32'sd0, POS_BOTTOM[31:0]};
    lim_hi   = '{32'sd18400, 32'sd18300, 32'sd74400, POS_TOP[31:0]};
    inv_mask = 4'h4;
    dir_bits = '0;
    endstops = '0;
    send_idle_pct = 32;
    recv_idle_pct = 59;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_cmd(CMD_TICK, 0, 1'b0);
    queue_cmd(CMD_STEP, 0, 1'b0);
    queue_cmd(CMD_STEP, 0, 1'b1);
    queue_cmd(CMD_DIR, 0, 1'b1);
    queue_cmd(CMD_STEP, 0, 1'b1);
    queue_cmd(CMD_STEP, 2, 1'b1);
    queue_cmd(CMD_DIR, 2, 1'b1);
    queue_cmd(CMD_STEP, 2, 1'b1);
    queue_cmd(CMD_STEP, 3, 1'b1);
    queue_cmd(CMD_DIR, 3, 1'b1);
    queue_cmd(CMD_STEP, 3, 1'b1);
    queue_cmd(CMD_DIR, 1, 1'b1);
    queue_cmd(CMD_STEP, 1, 1'b1);
    queue_cmd(CMD_DIR, 1, 1'b0);
    queue_cmd(CMD_UNUSED, 3, 1'b1);
    queue_cmd(CMD_UNUSED, 0, 1'b0);
    queue_cmd(CMD_TICK, 3, 1'b1);
    queue_cmd(CMD_TICK, 1, 1'b1);
    queue_cmd(CMD_STEP, 3, 1'b0);
    wait_drained();

    for (int k = 0; k < 6; k++) run_phase(k);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d command items through six limit and inversion settings,", items_sent);
    $display("with %0d register writes and %0d status items checked.",
             reg_writes, results_checked);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("tb_step_dir_axis_simulator passed");
    end else begin
      $display("tb_step_dir_axis_simulator failed");
    end
    $finish;
  end

endmodule

[step_dir_axis_simulator.f]
hdl/sdas_pkg.sv
hdl/sdas_front.sv
hdl/sdas_queue.sv
hdl/sdas_back.sv
hdl/step_dir_axis_simulator.sv
tb/tb_step_dir_axis_simulator.sv
